>>> rtl/brbf_pkg.sv
`default_nettype none

package brbf_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_LOG2_DEF = 10;
    localparam int MAX_BURST_DEF  = 64;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture the incoming transaction
        logic do_put;     // store the put byte if not full and load its result
        logic cnt_load;   // load the burst count
        logic rd_issue;   // read the store at the read offset, advance the pointer
        logic out_byte;   // load a result carrying the byte just read
        logic out_empty;  // load an empty get result
    } brbf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic op_in;       // op field of the offered transaction
        logic burst_zero;  // min(length, occupancy) is zero
        logic count_zero;  // no bytes left in the burst
        logic slot_free;   // output register can take a result this cycle
    } brbf_stat_t;

endpackage

`default_nettype wire

>>> rtl/brbf_ram.sv
`default_nettype none

module brbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, registered read port that holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/brbf_ctrl.sv
`default_nettype none

module brbf_ctrl
    import brbf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire brbf_stat_t stat,
    output brbf_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_SETUP,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = stat.op_in ? S_SETUP : S_PUT;
                end
            end
            S_PUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.do_put = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                if (!stat.burst_zero)
                begin
                    cmd.cnt_load = 1'b1;
                    state_next   = S_READ;
                end
                else if (stat.slot_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_byte = 1'b1;
                    state_next   = stat.count_zero ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/brbf_datapath.sv
`default_nettype none

module brbf_datapath
    import brbf_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire brbf_cmd_t         cmd,
    output brbf_stat_t             stat,
    input  wire logic              op,
    input  wire logic [BYTE_W-1:0] put_byte,
    input  wire logic [LEN_W-1:0]  get_length,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      read_byte,
    output logic                   byte_valid,
    output logic                   put_accepted,
    output logic                   last,
    output logic [DEPTH_LOG2:0]    occupancy,
    output logic [DEPTH_LOG2-1:0]  write_offset,
    output logic [DEPTH_LOG2-1:0]  read_offset
);

    localparam int PTR_W = DEPTH_LOG2 + 1;
    localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] read_byte_reg;
    logic              byte_valid_reg;
    logic              put_acc_reg;
    logic              last_reg;
    logic [PTR_W-1:0]  occ_reg;
    logic [DEPTH_LOG2-1:0] wo_reg;
    logic [DEPTH_LOG2-1:0] ro_reg;

    logic [PTR_W-1:0]  occ_now;
    logic [PTR_W-1:0]  occ_after;
    logic              full;
    logic              put_ok;
    logic              out_load;
    logic [LEN_W-1:0]  len_sat;
    logic [CMP_W-1:0]  occ_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  burst_ext;
    logic [BYTE_W-1:0] ram_rdata;

    // fill level and burst size
    assign occ_now   = wr_ptr_reg - rd_ptr_reg;
    assign full      = occ_now[DEPTH_LOG2];
    assign put_ok    = cmd.do_put && !full;
    assign len_sat   = (len_reg > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : len_reg;
    assign occ_ext   = CMP_W'(occ_now);
    assign len_ext   = CMP_W'(len_sat);
    assign burst_ext = (occ_ext < len_ext) ? occ_ext : len_ext;

    // advance pointers
    assign wr_ptr_next = put_ok ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = cmd.rd_issue ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign occ_after   = wr_ptr_next - rd_ptr_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_load)
        begin
            count_next = LEN_W'(burst_ext);
        end
        else if (cmd.rd_issue)
        begin
            count_next = count_reg - LEN_W'(1);
        end
    end

    // status to the controller
    assign out_load        = cmd.do_put || cmd.out_byte || cmd.out_empty;
    assign stat.op_in      = op;
    assign stat.burst_zero = (burst_ext == '0);
    assign stat.count_zero = (count_reg == '0);
    assign stat.slot_free  = !out_valid_reg || out_ready;

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    brbf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (put_ok),
        .wr_addr (wr_ptr_reg[DEPTH_LOG2-1:0]),
        .wr_data (byte_reg),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_ptr_reg[DEPTH_LOG2-1:0]),
        .rd_data (ram_rdata)
    );

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the transaction, count the burst, load results
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= put_byte;
            len_reg  <= get_length;
        end
        count_reg <= count_next;
        if (out_load)
        begin
            read_byte_reg  <= cmd.out_byte ? ram_rdata : '0;
            byte_valid_reg <= cmd.out_byte;
            put_acc_reg    <= put_ok;
            last_reg       <= cmd.out_byte ? stat.count_zero : 1'b1;
            occ_reg        <= occ_after;
            wo_reg         <= wr_ptr_next[DEPTH_LOG2-1:0];
            ro_reg         <= rd_ptr_next[DEPTH_LOG2-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_byte    = read_byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign put_accepted = put_acc_reg;
    assign last         = last_reg;
    assign occupancy    = occ_reg;
    assign write_offset = wo_reg;
    assign read_offset  = ro_reg;

endmodule

`default_nettype wire

>>> rtl/byte_ring_buffer_fifo.sv
// Channel   Handshake             Fields
// input     in_valid / in_ready   op, put_byte, get_length
// output    out_valid / out_ready read_byte, byte_valid, put_accepted, last,
//                                 occupancy, write_offset, read_offset
//
// A put is accepted in the idle state, then writes the store and loads its result.
// A get is accepted, then its burst count is loaded; each byte needs a read state
// and an output load state, set by the registered read port of the single store.
// An empty get ends in the setup state; a stalled output register holds the state.
// Reset clears both pointers and the output valid; the store is not cleared.
`default_nettype none

module byte_ring_buffer_fifo
    import brbf_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire logic [BYTE_W-1:0] put_byte,
    input  wire logic [LEN_W-1:0]  get_length,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [BYTE_W-1:0]      read_byte,
    output logic                   byte_valid,
    output logic                   put_accepted,
    output logic                   last,
    output logic [DEPTH_LOG2:0]    occupancy,
    output logic [DEPTH_LOG2-1:0]  write_offset,
    output logic [DEPTH_LOG2-1:0]  read_offset
);

    brbf_cmd_t  cmd;
    brbf_stat_t stat;

    brbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brbf_datapath #(
        .DEPTH_LOG2 (DEPTH_LOG2),
        .MAX_BURST  (MAX_BURST)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .put_byte     (put_byte),
        .get_length   (get_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_byte    (read_byte),
        .byte_valid   (byte_valid),
        .put_accepted (put_accepted),
        .last         (last),
        .occupancy    (occupancy),
        .write_offset (write_offset),
        .read_offset  (read_offset)
    );

endmodule

`default_nettype wire

>>> rtl/brbf_checker.sv
`default_nettype none

module brbf_checker
    import brbf_pkg::*;
#(
    parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [BYTE_W-1:0]     read_byte,
    input wire logic                  byte_valid,
    input wire logic                  put_accepted,
    input wire logic                  last,
    input wire logic [DEPTH_LOG2:0]   occupancy,
    input wire logic [DEPTH_LOG2-1:0] write_offset,
    input wire logic [DEPTH_LOG2-1:0] read_offset
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(last)
            && $stable(occupancy))
        else $error("stalled result changed");

    // a result carrying a byte never reports a stored put
    a_byte_not_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !put_accepted)
        else $error("byte result flagged as put");

    // a result with no byte ends its transaction and reads as zero
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && (read_byte == '0))
        else $error("empty result not last");

    // fill level stays within depth and matches the offsets
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= (DEPTH_LOG2 + 1)'(DEPTH))
            && (occupancy[DEPTH_LOG2-1:0] == DEPTH_LOG2'(write_offset - read_offset)))
        else $error("occupancy inconsistent");

    // no transaction is taken while a burst is running
    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid && !last |-> !in_ready)
        else $error("transaction accepted mid burst");

endmodule

bind byte_ring_buffer_fifo brbf_checker #(.DEPTH_LOG2(DEPTH_LOG2)) u_brbf_checker (.*);

`default_nettype wire

>>> bench/byte_ring_buffer_fifo_tb.sv
`default_nettype none

module byte_ring_buffer_fifo_tb;
    import brbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DL        = DEPTH_LOG2_DEF;
    localparam int BURST_MAX = MAX_BURST_DEF;
    localparam int DEPTH     = 1 << DL;
    localparam int LIMIT     = 2000000;
    localparam int HOLD_LEN  = 400;
    localparam int HOLD_AT   = 60;
    localparam int TAIL_WAIT = 40;

    typedef enum bit {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_code_e;

    typedef struct {
        op_code_e         op;
        bit [BYTE_W-1:0]  data;
        bit [LEN_W-1:0]   len;
        bit               calm;
    } fifo_cmd_t;

    typedef struct {
        bit [BYTE_W-1:0]  read_byte;
        bit               byte_valid;
        bit               put_accepted;
        bit               last;
        bit [DL:0]        occupancy;
        bit [DL-1:0]      write_offset;
        bit [DL-1:0]      read_offset;
    } ring_result_t;

    // DUT ports
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              op           = 1'b0;
    logic [BYTE_W-1:0] put_byte     = '0;
    logic [LEN_W-1:0]  get_length   = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              put_accepted;
    logic              last;
    logic [DL:0]       occupancy;
    logic [DL-1:0]     write_offset;
    logic [DL-1:0]     read_offset;

    // stimulus and scoreboard
    fifo_cmd_t    cmd_queue[$];
    ring_result_t ring_results_due[$];
    fifo_cmd_t    next_cmd;
    int           gen_fill;
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           in_count    = 0;
    logic         in_took     = 1'b0;
    logic         calm_phase  = 1'b0;
    int           send_gap    = 0;
    int           stall_left  = 0;
    int           hold_left   = 0;
    logic         hold_done   = 1'b0;

    // shadow copy of the FIFO
    bit [BYTE_W-1:0] shadow_store [DEPTH];
    bit [DL:0]       shadow_wr = '0;
    bit [DL:0]       shadow_rd = '0;

    byte_ring_buffer_fifo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .put_byte     (put_byte),
        .get_length   (get_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_byte    (read_byte),
        .byte_valid   (byte_valid),
        .put_accepted (put_accepted),
        .last         (last),
        .occupancy    (occupancy),
        .write_offset (write_offset),
        .read_offset  (read_offset)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // capture one result with the shadow pointers as they stand now
    function automatic ring_result_t snapshot(input bit [BYTE_W-1:0] b, input bit bv,
                                              input bit acc, input bit fin);
        ring_result_t r;
        r.read_byte    = b;
        r.byte_valid   = bv;
        r.put_accepted = acc;
        r.last         = fin;
        r.occupancy    = shadow_wr - shadow_rd;
        r.write_offset = shadow_wr[DL-1:0];
        r.read_offset  = shadow_rd[DL-1:0];
        return r;
    endfunction

    // advance the shadow FIFO by one transaction and queue its results
    task automatic predict_ring_results(input logic op_in, input logic [BYTE_W-1:0] b,
                                        input logic [LEN_W-1:0] len_in);
        bit [DL:0] fill;
        int        want;
        int        n;
        bit        ok;
        fill = shadow_wr - shadow_rd;
        if (op_in == OP_PUT)
        begin
            ok = (fill < DEPTH);
            if (ok)
            begin
                shadow_store[shadow_wr[DL-1:0]] = b;
                shadow_wr = shadow_wr + 1'b1;
            end
            ring_results_due.push_back(snapshot(8'h00, 1'b0, ok, 1'b1));
        end
        else
        begin
            want = (len_in > BURST_MAX) ? BURST_MAX : int'(len_in);
            n    = (want < int'(fill)) ? want : int'(fill);
            if (n == 0)
            begin
                ring_results_due.push_back(snapshot(8'h00, 1'b0, 1'b0, 1'b1));
            end
            else
            begin
                for (int k = 0; k < n; k++)
                begin
                    bit [BYTE_W-1:0] rb;
                    rb = shadow_store[shadow_rd[DL-1:0]];
                    shadow_rd = shadow_rd + 1'b1;
                    ring_results_due.push_back(snapshot(rb, 1'b1, 1'b0, (k + 1 == n)));
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // stimulus builders, tracking fill level so sequences can be shaped
    task automatic add_put(input bit [BYTE_W-1:0] b, input bit calm);
        fifo_cmd_t c;
        c.op   = OP_PUT;
        c.data = b;
        c.len  = LEN_W'($urandom);
        c.calm = calm;
        cmd_queue.push_back(c);
        if (gen_fill < DEPTH)
            gen_fill++;
    endtask

    task automatic add_get(input bit [LEN_W-1:0] len, input bit calm);
        fifo_cmd_t c;
        int        want;
        c.op   = OP_GET;
        c.data = BYTE_W'($urandom);
        c.len  = len;
        c.calm = calm;
        cmd_queue.push_back(c);
        want = (len > BURST_MAX) ? BURST_MAX : int'(len);
        gen_fill -= (want < gen_fill) ? want : gen_fill;
    endtask

    function automatic bit [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return LEN_W'($urandom_range(1, 16));
        else if (r < 85)
            return LEN_W'($urandom_range(17, BURST_MAX));
        else if (r < 90)
            return LEN_W'(BURST_MAX);
        else if (r < 95)
            return '0;
        else
            return LEN_W'($urandom_range(BURST_MAX + 1, (1 << LEN_W) - 1));
    endfunction

    task automatic add_mixed(input int count, input int put_pct, input bit calm);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < put_pct)
                add_put(BYTE_W'($urandom), calm);
            else
                add_get(pick_length(), calm);
        end
    endtask

    // flag transactions accepted at this edge and predict their results
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_ring_results(op, put_byte, get_length);
                in_count <= in_count + 1;
            end
        end
    end

    // offer queued transactions, with random idle bursts between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_took)
        begin
            // hold the offered transaction
        end
        else if (send_gap != 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (cmd_queue.size() != 0)
        begin
            next_cmd = cmd_queue.pop_front();
            in_valid   <= 1'b1;
            op         <= next_cmd.op;
            put_byte   <= next_cmd.data;
            get_length <= next_cmd.len;
            calm_phase <= next_cmd.calm;
            if (!next_cmd.calm && $urandom_range(0, 3) == 0)
                send_gap <= $urandom_range(1, 17);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // hold off the receiver once for a long stretch so the block backs up
    always @(negedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && in_count >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // drive out_ready with random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        ring_result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (ring_results_due.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                due = ring_results_due.pop_front();
                check_field("read_byte",    32'(due.read_byte),    32'(read_byte));
                check_field("byte_valid",   32'(due.byte_valid),   32'(byte_valid));
                check_field("put_accepted", 32'(due.put_accepted), 32'(put_accepted));
                check_field("last",         32'(due.last),         32'(last));
                check_field("occupancy",    32'(due.occupancy),    32'(occupancy));
                check_field("write_offset", 32'(due.write_offset), 32'(write_offset));
                check_field("read_offset",  32'(due.read_offset),  32'(read_offset));
            end
        end
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        gen_fill = 0;

        // directed: empty gets, zero and oversized lengths, byte extremes
        add_get(LEN_W'(1), 1'b0);
        add_get('0, 1'b0);
        add_put(8'h00, 1'b0);
        add_put(8'hFF, 1'b0);
        add_put(8'hA5, 1'b0);
        add_put(8'h5A, 1'b0);
        add_get('0, 1'b0);
        add_get(LEN_W'(2), 1'b0);
        add_get({LEN_W{1'b1}}, 1'b0);
        add_get(LEN_W'(BURST_MAX), 1'b0);
        add_put(8'h80, 1'b0);
        add_put(8'h7F, 1'b0);
        add_put(8'h55, 1'b0);
        add_put(8'hAA, 1'b0);
        add_put(8'h3C, 1'b0);
        add_get(LEN_W'(BURST_MAX + 1), 1'b0);
        add_put(8'hC3, 1'b0);
        add_get(LEN_W'(1), 1'b0);
        add_get(LEN_W'(1), 1'b0);
        add_put(8'h01, 1'b0);
        add_get(LEN_W'(BURST_MAX), 1'b0);

        // random: mixed traffic, then a calm tail with no idling
        add_mixed(100, 60, 1'b0);
        add_mixed(80, 50, 1'b0);
        add_mixed(60, 55, 1'b1);

        // release reset on a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every transaction to go in and every result to come out
        @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || ring_results_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/brbf_pkg.sv
rtl/brbf_ram.sv
rtl/brbf_ctrl.sv
rtl/brbf_datapath.sv
rtl/byte_ring_buffer_fifo.sv
rtl/brbf_checker.sv
bench/byte_ring_buffer_fifo_tb.sv
